// ===== src/bpru_pkg.sv =====
`timescale 1ns / 1ps

package bpru_pkg;

  // Largest frame the counters are sized for.
  localparam logic [10:0] MAX_WIDTH  = 11'd1024;
  localparam logic [10:0] MAX_HEIGHT = 11'd1024;

  localparam int SIZE_W  = 11;
  localparam int BPP_W   = 6;
  localparam int BASE_W  = 10;
  localparam int COORD_W = 11;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Supported pixel depths.
  localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
  localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

  // Byte phase code used in 24-bit mode while row padding is skipped.
  localparam logic [1:0] PHASE_PAD = 2'd3;

  // Alpha used for 24-bit pixels.
  localparam logic [7:0] ALPHA_24 = 8'h00;

  // Register reset values.
  localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 11'd1;
  localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 11'd1;
  localparam logic [BPP_W-1:0]  RST_BITS_PER_PIXEL = BPP_24;
  localparam logic [BASE_W-1:0] RST_ROW_BASE = 10'd300;
  localparam logic [BASE_W-1:0] RST_COL_BASE = 10'd795;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_BITS_PER_PIXEL = 3'd2,
    REG_ROW_BASE       = 3'd3,
    REG_COL_BASE       = 3'd4
  } cfg_reg_t;

  // Limits a size register to 1..maxv; zero acts as one.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = {{(SIZE_W-1){1'b0}}, 1'b1};
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/bmp_pixel_row_unpacker_unit.sv =====
`timescale 1ns / 1ps

// Bitmap pixel-array unpacker. Feed the pixel-array bytes of a bitmap, one
// byte per input transaction, in file order. With bits_per_pixel at 24 every
// three bytes (blue, green, red) give one result transaction with alpha zero,
// and the padding bytes that round each row up to a multiple of four bytes
// are swallowed without a result; with bits_per_pixel at 32 every four bytes
// (blue, green, red, alpha) give one result and there is no padding. Any
// other depth swallows bytes and leaves all state untouched. Each pixel is
// reported at screen_row = row_base - row and screen_col = col_base - column,
// both as 11-bit two's complement values, and last_pixel marks the final
// pixel of the image, after which the counters wrap for the next frame.
// Sizes are clamped to 1..1024. The block takes one byte per clock cycle
// unless a result is stalled: each byte is decoded in a single pass of small
// counter logic straight into the result register, so its result appears in
// the cycle after the byte is accepted. A result waiting in the output
// register under stall holds off further input; as soon as it is taken, a
// new byte is accepted in the same cycle. Configuration registers take
// effect immediately and should only be written while no transaction is in
// flight; the counters are not reset by a write.

module bmp_pixel_row_unpacker_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [bpru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpru_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Input byte channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          data_byte,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bpru_pkg::COORD_W-1:0] screen_row,
  output logic signed [bpru_pkg::COORD_W-1:0] screen_col,
  output logic [31:0]                         argb_color,
  output logic                                last_pixel
);

  // Configuration registers.
  logic [bpru_pkg::SIZE_W-1:0] image_width;
  logic [bpru_pkg::SIZE_W-1:0] image_height;
  logic [bpru_pkg::BPP_W-1:0]  bits_per_pixel;
  logic [bpru_pkg::BASE_W-1:0] row_base;
  logic [bpru_pkg::BASE_W-1:0] col_base;

  // Decoder state.
  logic [1:0]                 byte_phase;
  logic [23:0]                partial_pixel;
  logic [bpru_pkg::COL_W-1:0] column_index;
  logic [1:0]                 pad_index;
  logic [bpru_pkg::ROW_W-1:0] row_index;

  logic [1:0]                 byte_phase_next;
  logic [23:0]                partial_pixel_next;
  logic [bpru_pkg::COL_W-1:0] column_index_next;
  logic [1:0]                 pad_index_next;
  logic [bpru_pkg::ROW_W-1:0] row_index_next;

  logic                        in_accept;
  logic                        emit;
  logic                        is24;
  logic                        is32;
  logic [bpru_pkg::SIZE_W-1:0] width_eff;
  logic [bpru_pkg::SIZE_W-1:0] height_eff;
  logic                        row_end;
  logic                        img_end;
  logic [1:0]                  pad_count;
  logic [23:0]                 byte_shifted;
  logic [31:0]                 argb_next;

  // The output register is the only buffer: input waits only while a result
  // is held there under stall.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= bpru_pkg::RST_IMAGE_WIDTH;
      image_height   <= bpru_pkg::RST_IMAGE_HEIGHT;
      bits_per_pixel <= bpru_pkg::RST_BITS_PER_PIXEL;
      row_base       <= bpru_pkg::RST_ROW_BASE;
      col_base       <= bpru_pkg::RST_COL_BASE;
    end else if (cfg_we) begin
      case (cfg_index)
        bpru_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data;
        bpru_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data;
        bpru_pkg::REG_BITS_PER_PIXEL: bits_per_pixel <= cfg_data[bpru_pkg::BPP_W-1:0];
        bpru_pkg::REG_ROW_BASE:       row_base       <= cfg_data[bpru_pkg::BASE_W-1:0];
        bpru_pkg::REG_COL_BASE:       col_base       <= cfg_data[bpru_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign is24       = (bits_per_pixel == bpru_pkg::BPP_24);
  assign is32       = (bits_per_pixel == bpru_pkg::BPP_32);
  assign width_eff  = bpru_pkg::clamp_size(image_width, bpru_pkg::MAX_WIDTH);
  assign height_eff = bpru_pkg::clamp_size(image_height, bpru_pkg::MAX_HEIGHT);
  assign pad_count  = width_eff[1:0];

  // A counter that has run past a shrunken size wraps just as if it had hit
  // the limit, hence the greater-or-equal compares.
  assign row_end = ({1'b0, column_index} + 12'd1) >= {1'b0, width_eff};
  assign img_end = row_end &&
                   (({2'b00, row_index} + 12'd1) >= {1'b0, height_eff});

  always_comb begin
    byte_shifted = 24'd0;
    case (byte_phase)
      2'd0:    byte_shifted = {16'd0, data_byte};
      2'd1:    byte_shifted = {8'd0, data_byte, 8'd0};
      2'd2:    byte_shifted = {data_byte, 16'd0};
      default: byte_shifted = 24'd0;
    endcase
  end

  always_comb begin
    byte_phase_next    = byte_phase;
    partial_pixel_next = partial_pixel;
    column_index_next  = column_index;
    pad_index_next     = pad_index;
    row_index_next     = row_index;
    emit               = 1'b0;
    argb_next          = {bpru_pkg::ALPHA_24, data_byte, partial_pixel[15:0]};

    if (is24 && byte_phase == bpru_pkg::PHASE_PAD) begin
      // Skipping row padding. With no padding due, one byte is still dropped.
      if (({1'b0, pad_index} + 3'd1) >= {1'b0, pad_count}) begin
        pad_index_next  = 2'd0;
        byte_phase_next = 2'd0;
      end else begin
        pad_index_next = pad_index + 2'd1;
      end
    end else if ((is24 && byte_phase < 2'd2) || (is32 && byte_phase < 2'd3)) begin
      partial_pixel_next = partial_pixel | byte_shifted;
      byte_phase_next    = byte_phase + 2'd1;
    end else if (is24 || is32) begin
      emit = 1'b1;
      if (is32) begin
        argb_next = {data_byte, partial_pixel};
      end
      partial_pixel_next = 24'd0;
      if (row_end) begin
        column_index_next = '0;
        row_index_next    = img_end ? '0 : row_index + 1'b1;
        pad_index_next    = 2'd0;
        byte_phase_next   = (is24 && pad_count != 2'd0) ? bpru_pkg::PHASE_PAD : 2'd0;
      end else begin
        column_index_next = column_index + 1'b1;
        byte_phase_next   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= 2'd0;
      partial_pixel <= 24'd0;
      column_index  <= '0;
      pad_index     <= 2'd0;
      row_index     <= '0;
    end else if (in_accept) begin
      byte_phase    <= byte_phase_next;
      partial_pixel <= partial_pixel_next;
      column_index  <= column_index_next;
      pad_index     <= pad_index_next;
      row_index     <= row_index_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      screen_row <= {1'b0, row_base} - {1'b0, row_index};
      screen_col <= {1'b0, col_base} - column_index;
      argb_color <= argb_next;
      last_pixel <= img_end;
    end
  end

  // A depth that does not decode must leave the counters alone.
  a_other_depth_holds: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !is24 && !is32) |=>
      ($stable(byte_phase) && $stable(column_index) && $stable(row_index)))
    else $error("state changed on a byte of an unsupported depth");

  // The padding counter never reaches three: at most three pad bytes exist.
  a_pad_index_range: assert property (@(posedge clk) disable iff (rst)
    pad_index != 2'd3)
    else $error("padding counter out of range");

  // The last pixel of the image restarts the frame.
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_accept && emit && img_end) |=>
      (column_index == '0 && row_index == '0 && out_valid && last_pixel))
    else $error("frame did not wrap after the last pixel");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the bitmap pixel-array unpacker.
//
// Bytes are pushed through the input channel one transaction at a time. The
// bench keeps its own copy of the unpacker state (byte position, collected
// blue/green/red bytes, column, padding and row counters) and of the five
// configuration registers. Each accepted byte is run through that shadow
// copy; when a pixel completes, the expected screen coordinates and color
// are queued. Every result transaction is then checked, field by field,
// against the oldest queued pixel.
//
// The run opens with a short scripted sequence: reset-value decoding, the
// padding byte after a one-pixel row, all-zero and all-one bytes, both
// depths, coordinate extremes in both directions, unsupported depths, zero
// sizes, and a width change while padding is being skipped. After that,
// random phases follow. Each phase first lets the block drain, then
// rewrites a random subset of registers, then streams bytes. Small frames
// are sent whole most of the time, so rows and frames complete and the
// last-pixel flag fires often; the remaining phases send random byte counts.

module tb;
  import bpru_pkg::*;

  // Roughly this many decoded bytes are sent before the run winds down.
  localparam int ITEM_TARGET = 1750;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // Mismatch lines printed at most; later ones are only counted.
  localparam int SHOW_LIMIT = 40;
  // Extra idle cycles that cover any byte still in flight after the last result.
  localparam int DRAIN_CYCLES = 4;
  localparam int SCRIPT_LEN = 37;

  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TOP = '1;
  localparam logic [SIZE_W-1:0] SIZE_TOP = '1;
  localparam int BASE_TOP = (1 << BASE_W) - 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] row;
    logic signed [COORD_W-1:0] col;
    logic [31:0]               argb;
    logic                      last;
  } pixel_t;

  localparam pixel_t NO_PIXEL = '0;

  // A scripted row is a register write, a plain byte whose result (if any)
  // comes from the shadow model, or a byte whose pixel is spelled out here.
  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_PIXEL,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_reg_t              target;
    logic [CFG_DATA_W-1:0] value;
    logic [7:0]            data;
    pixel_t                want;
  } script_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   data_byte = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [COORD_W-1:0]    screen_row;
  logic signed [COORD_W-1:0]    screen_col;
  logic [31:0]                  argb_color;
  logic                         last_pixel;

  bmp_pixel_row_unpacker_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .screen_row (screen_row),
    .screen_col (screen_col),
    .argb_color (argb_color),
    .last_pixel (last_pixel)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow configuration registers.
  logic [SIZE_W-1:0] cfg_width;
  logic [SIZE_W-1:0] cfg_height;
  logic [BPP_W-1:0]  cfg_depth;
  logic [BASE_W-1:0] cfg_row_base;
  logic [BASE_W-1:0] cfg_col_base;

  // Shadow unpacker state.
  logic [1:0]        fill_phase;
  logic [23:0]       partial_bgr;
  logic [COL_W-1:0]  col_count;
  logic [1:0]        pad_count;
  logic [ROW_W-1:0]  row_count;

  pixel_t      pending_pixels[$];
  pixel_t      head_pixel;
  script_row_t script [SCRIPT_LEN];

  int mismatch_count = 0;
  int shown = 0;
  int field_errors;
  int decoded_items = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit stall_level = 1'b0;

  // A size of zero acts as one; anything above the maximum acts as the maximum.
  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v,
                                           input logic [SIZE_W-1:0] limit);
    return (v == '0) ? 1 : ((v > limit) ? int'(limit) : int'(v));
  endfunction

  // Closes a pixel: builds the expected result and steps column and row.
  task automatic finish_pixel(input logic [31:0] argb, input bit bgr_mode,
                              output pixel_t px);
    int unsigned w;
    int unsigned h;
    bit row_done;
    bit frame_done;
    w = eff_size(cfg_width, MAX_WIDTH);
    h = eff_size(cfg_height, MAX_HEIGHT);
    row_done = (col_count + 1 >= w);
    frame_done = row_done && (row_count + 1 >= h);
    px.row = {1'b0, cfg_row_base} - {1'b0, row_count};
    px.col = {1'b0, cfg_col_base} - col_count;
    px.argb = argb;
    px.last = frame_done;
    partial_bgr = '0;
    if (row_done) begin
      col_count = '0;
      row_count = frame_done ? '0 : row_count + 1'b1;
      pad_count = '0;
      // Only 24-bit rows carry padding, and only when the byte count is not
      // already a multiple of four.
      fill_phase = (bgr_mode && (w % 4 != 0)) ? PHASE_PAD : 2'd0;
    end else begin
      col_count = col_count + 1'b1;
      fill_phase = 2'd0;
    end
  endtask

  // Runs one accepted byte through the shadow model.
  task automatic unpack_byte(input logic [7:0] b, output bit emitted,
                             output pixel_t px);
    int unsigned pad_due;
    emitted = 1'b0;
    px = NO_PIXEL;
    if (cfg_depth == BPP_24) begin
      if (fill_phase == PHASE_PAD) begin
        // With no padding due, the byte is still swallowed once.
        pad_due = eff_size(cfg_width, MAX_WIDTH) % 4;
        if (pad_count + 1 >= pad_due) begin
          pad_count = '0;
          fill_phase = 2'd0;
        end else begin
          pad_count = pad_count + 1'b1;
        end
      end else if (fill_phase < 2'd2) begin
        partial_bgr = partial_bgr | (24'(b) << (8 * fill_phase));
        fill_phase = fill_phase + 1'b1;
      end else begin
        finish_pixel({ALPHA_24, b, partial_bgr[15:0]}, 1'b1, px);
        emitted = 1'b1;
      end
    end else if (cfg_depth == BPP_32) begin
      if (fill_phase < 2'd3) begin
        partial_bgr = partial_bgr | (24'(b) << (8 * fill_phase));
        fill_phase = fill_phase + 1'b1;
      end else begin
        finish_pixel({b, partial_bgr}, 1'b0, px);
        emitted = 1'b1;
      end
    end
  endtask

  // Writes one register and mirrors the write into the shadow copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:    cfg_width = v;
      REG_IMAGE_HEIGHT:   cfg_height = v;
      REG_BITS_PER_PIXEL: cfg_depth = v[BPP_W-1:0];
      REG_ROW_BASE:       cfg_row_base = v[BASE_W-1:0];
      REG_COL_BASE:       cfg_col_base = v[BASE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Sends one byte. The sender works in bursts; between bursts it may drop
  // valid for a random number of cycles.
  task automatic feed_byte(input logic [7:0] b, input bit typed,
                           input pixel_t typed_pixel);
    int unsigned gap;
    bit emitted;
    pixel_t px;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid = 1'b1;
    data_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (cfg_depth == BPP_24 || cfg_depth == BPP_32) decoded_items++;
    unpack_byte(b, emitted, px);
    if (typed) begin
      pending_pixels.push_back(typed_pixel);
    end else if (emitted) begin
      pending_pixels.push_back(px);
    end
  endtask

  // Holds the sender off until every expected pixel has come back, then waits
  // DRAIN_CYCLES more for a byte that produced no result.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random size: mostly small so frames finish, sometimes zero, the maximum,
  // or a value above the maximum that must be clamped.
  function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] limit,
                                                  input int unsigned typical);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return limit;
      2:       return SIZE_W'($urandom_range(limit + 1, SIZE_TOP));
      3:       return SIZE_W'($urandom_range(1, limit - 1));
      default: return SIZE_W'($urandom_range(1, typical));
    endcase
  endfunction

  // Random base coordinate; now and then a stray bit above the register width.
  function automatic logic [CFG_DATA_W-1:0] pick_base();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = CFG_DATA_W'(BASE_TOP);
      default: v = CFG_DATA_W'($urandom_range(0, BASE_TOP));
    endcase
    if ($urandom_range(0, 7) == 0) v[CFG_DATA_W-1] = 1'b1;
    return v;
  endfunction

  // The receiver stalls on its own pattern: short random on/off runs mixed
  // with longer stretches where it takes every result.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      if ($urandom_range(0, 9) < 3) begin
        stall_level = 1'b0;
        stall_left = $urandom_range(10, 60);
      end else begin
        stall_level = 1'($urandom_range(0, 1));
        stall_left = $urandom_range(1, 6);
      end
    end
    out_stall = stall_level;
    stall_left--;
  end

  task automatic show_mismatch(input string field, input longint want_v,
                               input longint got_v);
    if (shown < SHOW_LIMIT) begin
      $display("%0t: %s expected %0d, actual %0d", $time, field, want_v, got_v);
    end
    shown++;
    field_errors++;
  endtask

  // Result checker: every accepted result transaction is compared with the
  // oldest pending pixel.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        if (shown < SHOW_LIMIT) begin
          $display("%0t: result expected none, actual row %0d col %0d argb 0x%08h",
                   $time, screen_row, screen_col, argb_color);
        end
        shown++;
        mismatch_count++;
      end else begin
        head_pixel = pending_pixels.pop_front();
        field_errors = 0;
        if (screen_row !== head_pixel.row) begin
          show_mismatch("screen_row", head_pixel.row, screen_row);
        end
        if (screen_col !== head_pixel.col) begin
          show_mismatch("screen_col", head_pixel.col, screen_col);
        end
        if (argb_color !== head_pixel.argb) begin
          show_mismatch("argb_color", head_pixel.argb, argb_color);
        end
        if (last_pixel !== head_pixel.last) begin
          show_mismatch("last_pixel", head_pixel.last, last_pixel);
        end
        if (field_errors != 0) mismatch_count++;
      end
    end
  end

  // Watchdog: a run that stops moving for too long has hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** bmp_pixel_row_unpacker_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    bit writing;
    int unsigned w;
    int unsigned h;
    int unsigned frame;
    int unsigned n;
    logic [CFG_DATA_W-1:0] v;

    // Shadow state starts at the reset values.
    cfg_width = RST_IMAGE_WIDTH;
    cfg_height = RST_IMAGE_HEIGHT;
    cfg_depth = RST_BITS_PER_PIXEL;
    cfg_row_base = RST_ROW_BASE;
    cfg_col_base = RST_COL_BASE;
    fill_phase = '0;
    partial_bgr = '0;
    col_count = '0;
    pad_count = '0;
    row_count = '0;

    // Scripted opening. Out of reset the frame is one pixel at (300, 795),
    // 24 bits deep, so each pixel is the last one and is followed by a
    // single padding byte.
    script = '{
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h00, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h00, NO_PIXEL},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,    11'd0,    8'h00,
        '{11'sd300, 11'sd795, 32'h0000_0000, 1'b1}},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h5A, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'hFF, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'hFF, NO_PIXEL},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,    11'd0,    8'hFF,
        '{11'sd300, 11'sd795, 32'h00FF_FFFF, 1'b1}},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'hA5, NO_PIXEL},
      // 32-bit pixels, two rows of one pixel, row base at zero so the
      // second row lands at screen row -1.
      '{ROW_WRITE, REG_BITS_PER_PIXEL, 11'd32,   8'h00, NO_PIXEL},
      '{ROW_WRITE, REG_ROW_BASE,       11'd0,    8'h00, NO_PIXEL},
      '{ROW_WRITE, REG_COL_BASE,       11'd1023, 8'h00, NO_PIXEL},
      '{ROW_WRITE, REG_IMAGE_HEIGHT,   11'd2,    8'h00, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'hFF, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'hFF, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'hFF, NO_PIXEL},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,    11'd0,    8'hFF,
        '{11'sd0, 11'sd1023, 32'hFFFF_FFFF, 1'b0}},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h01, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h02, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h03, NO_PIXEL},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,    11'd0,    8'h04,
        '{-11'sd1, 11'sd1023, 32'h0403_0201, 1'b1}},
      // Unsupported depths swallow bytes without touching any state.
      '{ROW_WRITE, REG_BITS_PER_PIXEL, 11'd0,    8'h00, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h77, NO_PIXEL},
      '{ROW_WRITE, REG_BITS_PER_PIXEL, 11'd63,   8'h00, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h88, NO_PIXEL},
      // Zero sizes act as one.
      '{ROW_WRITE, REG_BITS_PER_PIXEL, 11'd24,   8'h00, NO_PIXEL},
      '{ROW_WRITE, REG_IMAGE_WIDTH,    11'd0,    8'h00, NO_PIXEL},
      '{ROW_WRITE, REG_IMAGE_HEIGHT,   11'd0,    8'h00, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h10, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h20, NO_PIXEL},
      '{ROW_PIXEL, REG_IMAGE_WIDTH,    11'd0,    8'h30,
        '{11'sd0, 11'sd1023, 32'h0030_2010, 1'b1}},
      // The block now waits on a padding byte. A width of four means no
      // padding is due, yet one byte is still skipped.
      '{ROW_WRITE, REG_IMAGE_WIDTH,    11'd4,    8'h00, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h99, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h0F, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'hF0, NO_PIXEL},
      '{ROW_BYTE,  REG_IMAGE_WIDTH,    11'd0,    8'h3C, NO_PIXEL},
      // Oversized width gets clamped; left in place mid-row on purpose.
      '{ROW_WRITE, REG_IMAGE_WIDTH,    11'd2047, 8'h00, NO_PIXEL},
      '{ROW_WRITE, REG_ROW_BASE,       11'd1023, 8'h00, NO_PIXEL}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    writing = 1'b0;
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (script[i].kind == ROW_WRITE) begin
        // Registers only change once the block has gone quiet.
        if (!writing) settle();
        writing = 1'b1;
        write_reg(script[i].target, script[i].value);
      end else begin
        writing = 1'b0;
        feed_byte(script[i].data, script[i].kind == ROW_PIXEL, script[i].want);
      end
    end

    // Random phases. Each one drains the block, rewrites some registers and
    // then streams bytes. The counters are not reset by a write, so a phase
    // may start mid-pixel or mid-row under a new depth or size.
    while (decoded_items < ITEM_TARGET) begin
      settle();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_IMAGE_WIDTH, pick_size(MAX_WIDTH, 8));
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_IMAGE_HEIGHT, pick_size(MAX_HEIGHT, 4));
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3, 4, 5, 6:         v = CFG_DATA_W'(BPP_24);
          7, 8, 9, 10, 11, 12, 13:     v = CFG_DATA_W'(BPP_32);
          default:                     v = CFG_DATA_W'($urandom_range(0, 63));
        endcase
        // Bits above the depth register are ignored by the block.
        if ($urandom_range(0, 7) == 0) begin
          v[CFG_DATA_W-1:BPP_W] = (CFG_DATA_W-BPP_W)'($urandom);
        end
        write_reg(REG_BITS_PER_PIXEL, v);
      end
      if ($urandom_range(0, 1) == 0) write_reg(REG_ROW_BASE, pick_base());
      if ($urandom_range(0, 1) == 0) write_reg(REG_COL_BASE, pick_base());
      // Writes to unmapped indexes must have no effect.
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_COL_BASE + 1, CFG_INDEX_TOP)),
                  CFG_DATA_W'($urandom));
      end

      w = eff_size(cfg_width, MAX_WIDTH);
      h = eff_size(cfg_height, MAX_HEIGHT);
      if (cfg_depth == BPP_24) begin
        frame = h * (3 * w + w % 4);
      end else if (cfg_depth == BPP_32) begin
        frame = 4 * w * h;
      end else begin
        frame = 0;
      end
      // Mostly whole frames, otherwise a ragged byte count.
      if (frame != 0 && frame <= 240 && $urandom_range(0, 3) != 0) begin
        n = frame * $urandom_range(1, 2);
      end else begin
        n = $urandom_range(1, 120);
      end
      repeat (n) feed_byte(8'($urandom_range(0, 255)), 1'b0, NO_PIXEL);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("** bmp_pixel_row_unpacker_unit: PASSED **");
    end else begin
      $display("** bmp_pixel_row_unpacker_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bpru_pkg.sv
src/bmp_pixel_row_unpacker_unit.sv
tb/tb.sv
